// ===== hw/rtl/prd_pkg.sv =====
// ============================================================================
// prd_pkg: shared types and constants for the pulse rate detector
// Transaction payload structs, fixed field widths, configuration port widths,
// register indexes, reset values and arithmetic constants.
// ============================================================================
package prd_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 10;
  localparam int TICK_BITS   = 8;
  localparam int PERIOD_BITS = 24;
  localparam int RATE_BITS   = 16;

  // Configuration port widths
  localparam int CFG_DATA_BITS  = 10;
  localparam int CFG_INDEX_BITS = 2;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROXIMITY_BOUND = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_BOUND     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TICK_MS         = 2'd2;

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0] PROXIMITY_BOUND_RST = 10'd868;
  localparam logic [SAMPLE_BITS-1:0] PULSE_BOUND_RST     = 10'd310;
  localparam logic [TICK_BITS-1:0]   TICK_MS_RST         = 8'd10;

  // Arithmetic constants
  localparam logic [RATE_BITS-1:0]   RATE_NUMERATOR = 16'd60000;
  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX     = 24'hFF_FFFF;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] finger_sample;
    logic [SAMPLE_BITS-1:0] heart_sample;
  } prd_in_t;

  typedef struct packed {
    logic                   finger_present;
    logic                   beat;
    logic [PERIOD_BITS-1:0] period_ms;
    logic [RATE_BITS-1:0]   rate_bpm;
    logic                   rate_valid;
  } prd_out_t;

endpackage

// ===== hw/rtl/pulse_rate_detector_core.sv =====
// ============================================================================
// pulse_rate_detector_core: threshold heartbeat rate detector
// Finger presence, beat detection on a rising crossing of the pulse bound,
// tick counting between beats, period in ms and integer BPM by a restoring
// divider that produces one quotient bit per cycle.
// ============================================================================
//
//  channel | signals                      | payload
//  --------+------------------------------+--------------------------
//  in      | in_valid, in_stall           | in_data  (prd_in_t)
//  out     | out_valid, out_stall         | out_data (prd_out_t)
//  cfg     | cfg_wr_en, cfg_index         | cfg_data (10 bits)
//
//  A non-beat transaction goes from S_IDLE to S_LOAD and back to idle. A beat
//  passes S_MUL first; with a nonzero period it then runs S_DIV, the 16
//  shift-subtract steps of the divider, before S_LOAD.
//  One transaction at a time; in_stall is high from accept until the result
//  is loaded into the output register, which waits until the previous result
//  is taken; a new transaction can then run while that result is stalled.
//  rst is synchronous, active high; it restores the register reset values.
//
module pulse_rate_detector_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input transactions
  input  logic                                in_valid,
  output logic                                in_stall,
  input  prd_pkg::prd_in_t                    in_data,
  // result transactions
  output logic                                out_valid,
  input  logic                                out_stall,
  output prd_pkg::prd_out_t                   out_data,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [prd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [prd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int PROD_W = COUNT_BITS + prd_pkg::TICK_BITS;
  localparam int CMP_W  = (PROD_W > prd_pkg::PERIOD_BITS) ? PROD_W : prd_pkg::PERIOD_BITS;
  localparam int RB     = prd_pkg::RATE_BITS;
  localparam int STEP_W = $clog2(RB);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_LOAD
  } state_t;

  state_t state;

  // configuration registers
  logic [prd_pkg::SAMPLE_BITS-1:0] proximity_bound;
  logic [prd_pkg::SAMPLE_BITS-1:0] pulse_bound;
  logic [prd_pkg::TICK_BITS-1:0]   tick_ms;

  // detector state
  logic                  in_peak;
  logic [COUNT_BITS-1:0] tick_count;

  // per-transaction working registers
  logic                            res_present;
  logic                            res_beat;
  logic                            res_valid;
  logic [COUNT_BITS-1:0]           cnt_snap;
  logic [prd_pkg::TICK_BITS-1:0]   tick_snap;
  logic [prd_pkg::PERIOD_BITS-1:0] period;
  logic [RB-1:0]                   rem;
  logic [RB-1:0]                   quo;
  logic [STEP_W-1:0]               step;

  logic accept;
  logic present;
  logic beat;

  logic [PROD_W-1:0]               product;
  logic [CMP_W-1:0]                prod_ext;
  logic [prd_pkg::PERIOD_BITS-1:0] period_sat;

  logic [RB:0]                     trial;
  logic [prd_pkg::PERIOD_BITS-1:0] trial_ext;
  logic [prd_pkg::PERIOD_BITS-1:0] diff;
  logic                            ge;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // beat detection on the incoming sample
  assign present = (in_data.finger_sample < proximity_bound);
  assign beat    = present && !in_peak && (in_data.heart_sample > pulse_bound);

  // multiply and saturate to the period width
  assign product  = PROD_W'(cnt_snap) * PROD_W'(tick_snap);
  assign prod_ext = CMP_W'(product);
  assign period_sat = (prod_ext > CMP_W'(prd_pkg::PERIOD_MAX)) ?
                      prd_pkg::PERIOD_MAX : prod_ext[prd_pkg::PERIOD_BITS-1:0];

  // one restoring divide step
  assign trial     = {rem, quo[RB-1]};
  assign trial_ext = prd_pkg::PERIOD_BITS'(trial);
  assign ge        = (trial_ext >= period);
  assign diff      = trial_ext - period;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      proximity_bound <= prd_pkg::PROXIMITY_BOUND_RST;
      pulse_bound     <= prd_pkg::PULSE_BOUND_RST;
      tick_ms         <= prd_pkg::TICK_MS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        prd_pkg::REG_PROXIMITY_BOUND: proximity_bound <= cfg_data;
        prd_pkg::REG_PULSE_BOUND:     pulse_bound     <= cfg_data;
        prd_pkg::REG_TICK_MS:         tick_ms         <= cfg_data[prd_pkg::TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, detector state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_peak    <= 1'b0;
      tick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // result taken; S_LOAD handles the output register itself
      if (out_valid && !out_stall && (state != S_LOAD)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_present <= present;
            res_beat    <= beat;
            res_valid   <= 1'b0;
            period      <= '0;
            cnt_snap    <= tick_count;
            tick_snap   <= tick_ms;
            if (present) begin
              if (beat) begin
                in_peak    <= 1'b1;
                tick_count <= '0;
              end else begin
                if (tick_count != '1) begin
                  tick_count <= tick_count + 1'b1;
                end
                if (in_peak && (in_data.heart_sample < pulse_bound)) begin
                  in_peak <= 1'b0;
                end
              end
            end
            state <= beat ? S_MUL : S_LOAD;
          end
        end
        S_MUL: begin
          period <= period_sat;
          rem    <= '0;
          quo    <= prd_pkg::RATE_NUMERATOR;
          step   <= '0;
          if (period_sat != '0) begin
            res_valid <= 1'b1;
            state     <= S_DIV;
          end else begin
            state <= S_LOAD;
          end
        end
        S_DIV: begin
          rem  <= ge ? diff[RB-1:0] : trial[RB-1:0];
          quo  <= {quo[RB-2:0], ge};
          step <= step + 1'b1;
          if (step == STEP_W'(RB - 1)) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!out_valid || !out_stall) begin
            out_valid               <= 1'b1;
            out_data.finger_present <= res_present;
            out_data.beat           <= res_beat;
            out_data.period_ms      <= period;
            out_data.rate_bpm       <= res_valid ? quo : '0;
            out_data.rate_valid     <= res_valid;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a valid rate only comes with a beat
  a_valid_needs_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.rate_valid |-> out_data.beat)
    else $error("rate_valid without beat");

  // non-beat results carry zero period and rate
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.beat |-> (out_data.period_ms == '0) && (out_data.rate_bpm == '0))
    else $error("nonzero period or rate without beat");

  // a beat needs a finger
  a_beat_needs_finger: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.beat |-> out_data.finger_present)
    else $error("beat without finger present");

  // busy right after accepting a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");
`endif

endmodule
